[hdl/sbwpd_pkg.sv]
// sbwpd_pkg: shared types and constants for the sixty-bit word parcel decoder
// holds the opcode summary struct, register kind codes and operation class codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sbwpd_pkg;

  localparam int DIGITS_PER_WORD = 20;
  localparam int DIGIT_W         = 3;
  localparam int WORD_W          = DIGITS_PER_WORD * DIGIT_W;
  localparam int PARCEL_W        = 5 * DIGIT_W;
  localparam int LONG_K_W        = 18;

  localparam logic [1:0] RK_NONE = 2'd0;
  localparam logic [1:0] RK_X    = 2'd1;
  localparam logic [1:0] RK_B    = 2'd2;

  localparam logic [3:0] CLS_INVALID   = 4'd0;
  localparam logic [3:0] CLS_STOP      = 4'd1;
  localparam logic [3:0] CLS_BRANCH    = 4'd2;
  localparam logic [3:0] CLS_BR_LONG   = 4'd3;
  localparam logic [3:0] CLS_BR_INC    = 4'd4;
  localparam logic [3:0] CLS_BOOLEAN   = 4'd5;
  localparam logic [3:0] CLS_SHIFT     = 4'd6;
  localparam logic [3:0] CLS_NORMALIZE = 4'd7;
  localparam logic [3:0] CLS_FADD      = 4'd8;
  localparam logic [3:0] CLS_IADD      = 4'd9;
  localparam logic [3:0] CLS_FMUL      = 4'd10;
  localparam logic [3:0] CLS_FDIV      = 4'd11;
  localparam logic [3:0] CLS_NOOP      = 4'd12;
  localparam logic [3:0] CLS_POPCOUNT  = 4'd13;
  localparam logic [3:0] CLS_INCREMENT = 4'd14;

  typedef struct packed {
    logic [3:0] op_class;
    logic [1:0] kind_i;
    logic [1:0] kind_j;
    logic [1:0] kind_k;
    logic       lng;
  } op_info_t;

endpackage

`default_nettype wire

[hdl/sixty_bit_word_parcel_decoder_unit.sv]
// sixty_bit_word_parcel_decoder_unit: splits a 60-bit word into 15/30-bit parcels
// each word is loaded into the parcel shift register; the outputs are registered
// throughput: one decoded instruction per cycle while result_stall is low, set by
//   the parcel shift register that moves one parcel (or two for long) per cycle
// reset: synchronous, clears the sequencer and the output valid
// depends on sbwpd_pkg and sbwpd_opdec
`timescale 1ns / 1ps
`default_nettype none

module sixty_bit_word_parcel_decoder_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        word_valid,
  output logic             word_stall,
  input  wire logic [59:0] instruction_word,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [3:0]       operation_class,
  output logic [1:0]       first_reg_kind,
  output logic [1:0]       second_reg_kind,
  output logic [1:0]       third_reg_kind,
  output logic [2:0]       field_i,
  output logic [2:0]       field_j,
  output logic [17:0]      field_k,
  output logic             is_long,
  output logic [1:0]       parcel_position,
  output logic             long_at_end,
  output logic             last
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_t;

  state_t                              state;
  logic [1:0]                          pidx;
  logic [sbwpd_pkg::WORD_W-1:0]        word_sr;
  sbwpd_pkg::op_info_t                 info;
  logic                                long_here;
  logic                                at_end;
  logic                                fin;
  logic                                emit;
  logic                                take;

  sbwpd_opdec u_opdec (
    .op_hi (word_sr[59:57]),
    .op_lo (word_sr[56:54]),
    .info  (info)
  );

  assign long_here  = info.lng && (pidx != 2'd3);
  assign at_end     = info.lng && (pidx == 2'd3);
  assign fin        = (pidx == 2'd3) || ((pidx == 2'd2) && long_here);
  assign emit       = (state == S_WALK) && (!result_valid || !result_stall);
  assign word_stall = rst || !((state == S_IDLE) || (emit && fin));
  assign take       = word_valid && !word_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pidx         <= 2'd0;
      result_valid <= 1'b0;
    end else begin
      if (take) begin
        state <= S_WALK;
        pidx  <= 2'd0;
      end else if (emit) begin
        if (fin) state <= S_IDLE;
        pidx <= pidx + (long_here ? 2'd2 : 2'd1);
      end
      if (emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // parcel shift register, leading parcel at the top
  always_ff @(posedge clk) begin
    if (take) begin
      word_sr <= instruction_word;
    end else if (emit) begin
      if (long_here) begin
        word_sr <= {word_sr[29:0], 30'd0};
      end else begin
        word_sr <= {word_sr[44:0], 15'd0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      operation_class <= info.op_class;
      first_reg_kind  <= info.kind_i;
      second_reg_kind <= info.kind_j;
      third_reg_kind  <= info.kind_k;
      field_i         <= word_sr[53:51];
      field_j         <= word_sr[50:48];
      field_k         <= long_here ? word_sr[47:30] : {15'd0, word_sr[47:45]};
      is_long         <= long_here;
      parcel_position <= pidx;
      long_at_end     <= at_end;
      last            <= fin;
    end
  end

endmodule

`default_nettype wire

[hdl/sbwpd_opdec.sv]
// sbwpd_opdec: opcode classifier for one instruction parcel
// maps the two leading octal digits to class, register kinds and length
// depends on sbwpd_pkg
`timescale 1ns / 1ps
`default_nettype none

module sbwpd_opdec (
  input  wire logic [2:0]          op_hi,
  input  wire logic [2:0]          op_lo,
  output sbwpd_pkg::op_info_t      info
);

  always_comb begin
    info.op_class = sbwpd_pkg::CLS_INVALID;
    info.kind_i   = sbwpd_pkg::RK_NONE;
    info.kind_j   = sbwpd_pkg::RK_NONE;
    info.kind_k   = sbwpd_pkg::RK_NONE;
    info.lng      = 1'b0;
    case (op_hi)
      3'd0: begin
        info.lng = 1'b1;
        case (op_lo)
          3'd0: begin
            info.op_class = sbwpd_pkg::CLS_STOP;
            info.lng      = 1'b0;
          end
          3'd1: info.op_class = sbwpd_pkg::CLS_BRANCH;
          3'd2: begin
            info.op_class = sbwpd_pkg::CLS_BRANCH;
            info.kind_i   = sbwpd_pkg::RK_B;
          end
          3'd3: begin
            info.op_class = sbwpd_pkg::CLS_BR_LONG;
            info.kind_j   = sbwpd_pkg::RK_X;
          end
          default: begin
            info.op_class = sbwpd_pkg::CLS_BR_INC;
            info.kind_i   = sbwpd_pkg::RK_B;
          end
        endcase
      end
      3'd1: begin
        info.op_class = sbwpd_pkg::CLS_BOOLEAN;
        info.kind_i   = sbwpd_pkg::RK_X;
        info.kind_j   = (op_lo == 3'd4) ? sbwpd_pkg::RK_NONE : sbwpd_pkg::RK_X;
        info.kind_k   = (op_lo == 3'd0) ? sbwpd_pkg::RK_NONE : sbwpd_pkg::RK_X;
      end
      3'd2: begin
        if (op_lo == 3'd5) begin
          info.op_class = sbwpd_pkg::CLS_NORMALIZE;
        end else begin
          info.op_class = sbwpd_pkg::CLS_SHIFT;
          info.kind_i   = sbwpd_pkg::RK_X;
          if (op_lo >= 3'd2) info.kind_j = sbwpd_pkg::RK_B;
          if (op_lo == 3'd4 || op_lo >= 3'd6) info.kind_k = sbwpd_pkg::RK_X;
        end
      end
      3'd3: begin
        info.op_class = (op_lo <= 3'd5) ? sbwpd_pkg::CLS_FADD : sbwpd_pkg::CLS_IADD;
        info.kind_i   = sbwpd_pkg::RK_X;
        info.kind_j   = sbwpd_pkg::RK_X;
        info.kind_k   = sbwpd_pkg::RK_X;
      end
      3'd4: begin
        case (op_lo) inside
          [3'd0:3'd2]: info.op_class = sbwpd_pkg::CLS_FMUL;
          3'd3:        info.op_class = sbwpd_pkg::CLS_SHIFT;
          [3'd4:3'd5]: begin
            info.op_class = sbwpd_pkg::CLS_FDIV;
            info.kind_i   = sbwpd_pkg::RK_X;
            info.kind_j   = sbwpd_pkg::RK_X;
            info.kind_k   = sbwpd_pkg::RK_X;
          end
          3'd6:        info.op_class = sbwpd_pkg::CLS_NOOP;
          default: begin
            info.op_class = sbwpd_pkg::CLS_POPCOUNT;
            info.kind_i   = sbwpd_pkg::RK_X;
            info.kind_k   = sbwpd_pkg::RK_X;
          end
        endcase
      end
      default: begin
        info.op_class = sbwpd_pkg::CLS_INCREMENT;
        info.lng      = (op_lo <= 3'd2);
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/sbwpd_checker.sv]
// sbwpd_checker: port-level assertions for the parcel decoder
// bound to sixty_bit_word_parcel_decoder_unit, sees its ports only
// depends on sixty_bit_word_parcel_decoder_unit
`timescale 1ns / 1ps
`default_nettype none

module sbwpd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        result_valid,
  input wire logic        result_stall,
  input wire logic [3:0]  operation_class,
  input wire logic        is_long,
  input wire logic [1:0]  parcel_position,
  input wire logic        long_at_end,
  input wire logic        last
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(operation_class)
      && $stable(parcel_position) && $stable(last))
    else $error("stalled transaction changed");

  a_long_fits: assert property (@(posedge clk) disable iff (rst)
    result_valid && is_long |-> parcel_position != 2'd3 && !long_at_end)
    else $error("long instruction in final parcel");

  a_end_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid && long_at_end |-> parcel_position == 2'd3 && last)
    else $error("long_at_end outside final parcel");

  a_final_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && parcel_position == 2'd3 |-> last)
    else $error("final parcel not marked last");

endmodule

bind sixty_bit_word_parcel_decoder_unit sbwpd_checker u_sbwpd_checker (
  .clk             (clk),
  .rst             (rst),
  .result_valid    (result_valid),
  .result_stall    (result_stall),
  .operation_class (operation_class),
  .is_long         (is_long),
  .parcel_position (parcel_position),
  .long_at_end     (long_at_end),
  .last            (last)
);

`default_nettype wire
